// File: rtl/oldest_first_lock_arbiter_core_defines.svh
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter: assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef OLDEST_FIRST_LOCK_ARBITER_CORE_DEFINES_SVH
`define OLDEST_FIRST_LOCK_ARBITER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFLA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OFLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ofla_pkg.sv
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter package
// Types, codes and sizing constants shared by the arbiter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofla_pkg;

   // Field widths and default sizing.
   localparam int SLOT_COUNT_DEF = 64;
   localparam int SLOT_W         = 6;
   localparam int TIME_W         = 64;
   localparam int QUEUE_DEPTH    = 2;

   // Status codes on the result beat.
   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_IDLE_RELEASE = 1'b1;

   // Request kinds.
   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   // Execution unit states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   // A classified request waiting for execution.
   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic                in_range;
      logic [TIME_W-1:0]   stamp;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic                grant_valid;
      logic [SLOT_W-1:0]   grant_slot;
      logic                request_queued;
      logic                lock_busy;
      logic                status;
   } rsp_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Flow control seen by the intake.
   typedef struct packed {
      logic queue_full;
      logic clearing;
   } front_ctl_type;

endpackage

// File: rtl/ofla_queue.sv
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter command queue
// Short FIFO between the intake and the execution unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oldest_first_lock_arbiter_core_defines.svh"

module ofla_queue
   import ofla_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == FULL_CNT);
   assign q_stat.empty = (count_ff == '0);

   `OFLA_ASSERT_IMPLY(a_queue_no_overflow, push, !q_stat.full || pop, "queue written while full")
   `OFLA_ASSERT_IMPLY(a_queue_no_underflow, pop, !q_stat.empty, "queue read while empty")

endmodule

// File: rtl/ofla_intake.sv
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter intake
// Accepts request beats, classifies them and pushes them into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofla_intake
   import ofla_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
   input  logic                start,
   input  logic                req_mode,
   input  logic [SLOT_W-1:0]   req_requester_slot,
   input  logic [TIME_W-1:0]   req_request_time,
   input  front_ctl_type       ctl,
   output logic                busy,
   output logic                push,
   output cmd_type             push_cmd
);

   // Hold off new beats while the queue is full or the pending store is cleared.
   assign busy = ctl.queue_full || ctl.clearing;
   assign push = start && !busy;

   // Classify the beat; a slot beyond the store is never recorded.
   always_comb begin
      push_cmd.op       = req_mode ? OP_RELEASE : OP_ACQUIRE;
      push_cmd.slot     = req_requester_slot;
      push_cmd.in_range = (32'(req_requester_slot) < 32'(SLOT_COUNT));
      push_cmd.stamp    = req_request_time;
   end

endmodule

// File: rtl/ofla_exec.sv
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter execution unit
// Holds the lock state and pending store, runs the oldest-request scan.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oldest_first_lock_arbiter_core_defines.svh"

module ofla_exec
   import ofla_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  cmd_type          pop_cmd,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_valid,
   output rsp_type          rsp
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOT_COUNT);

   // Pending store: valid bit over timestamp, one entry per slot.
   logic [TIME_W:0]     mem [SLOT_COUNT];
   logic [TIME_W:0]     rd_ff;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                live_ff, live_in;
   logic [IDX_W-1:0]    live_idx_ff, live_idx_in;
   logic                best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]   best_time_ff, best_time_in;
   logic                lock_held_ff, lock_held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                scan_done;
   logic                issue;
   logic                we;
   logic [IDX_W-1:0]    waddr;
   logic [TIME_W:0]     wdata;
   logic [IDX_W-1:0]    raddr;

   // The last read has been compared once every slot was issued.
   assign scan_done = (scan_ff == SCAN_END) && !live_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_stat.empty && pop_cmd.op == OP_RELEASE && lock_held_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs: queue pop and memory port control.
   always_comb begin
      pop   = 1'b0;
      issue = 1'b0;
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
         end
         ST_IDLE: begin
            pop = !q_stat.empty;
            if (pop && pop_cmd.op == OP_ACQUIRE && lock_held_ff && pop_cmd.in_range) begin
               we    = 1'b1;
               waddr = IDX_W'(pop_cmd.slot);
               wdata = {1'b1, pop_cmd.stamp};
            end
         end
         ST_SCAN: begin
            issue = (scan_ff != SCAN_END);
            if (issue) begin
               raddr = scan_ff[IDX_W-1:0];
            end
            if (scan_done && best_valid_ff) begin
               we    = 1'b1;
               waddr = best_idx_ff;
               wdata = {1'b0, best_time_ff};
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Datapath next values: lock state, scan tracking and the result beat.
   always_comb begin
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      live_in       = 1'b0;
      live_idx_in   = live_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      lock_held_in  = lock_held_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end

      if (pop) begin
         if (pop_cmd.op == OP_ACQUIRE) begin
            rsp_valid_in = 1'b1;
            if (!lock_held_ff) begin
               // Idle lock: grant at once.
               lock_held_in = 1'b1;
               rsp_in = '{grant_valid: 1'b1, grant_slot: pop_cmd.slot,
                          request_queued: 1'b0, lock_busy: 1'b1, status: STATUS_OK};
            end else begin
               rsp_in = '{grant_valid: 1'b0, grant_slot: '0,
                          request_queued: pop_cmd.in_range, lock_busy: 1'b1,
                          status: STATUS_OK};
            end
         end else if (!lock_held_ff) begin
            // Release of an idle lock is flagged and ignored.
            rsp_valid_in = 1'b1;
            rsp_in = '{grant_valid: 1'b0, grant_slot: '0, request_queued: 1'b0,
                       lock_busy: 1'b0, status: STATUS_IDLE_RELEASE};
         end else begin
            scan_in       = '0;
            best_valid_in = 1'b0;
         end
      end

      if (state_ff == ST_SCAN) begin
         // Issue one read per cycle in ascending slot order.
         if (issue) begin
            scan_in     = scan_ff + 1'b1;
            live_in     = 1'b1;
            live_idx_in = scan_ff[IDX_W-1:0];
         end
         // Strictly older wins, so the lowest slot keeps a tie.
         if (live_ff && rd_ff[TIME_W] &&
             (!best_valid_ff || rd_ff[TIME_W-1:0] < best_time_ff)) begin
            best_valid_in = 1'b1;
            best_idx_in   = live_idx_ff;
            best_time_in  = rd_ff[TIME_W-1:0];
         end
         if (scan_done) begin
            rsp_valid_in = 1'b1;
            if (best_valid_ff) begin
               rsp_in = '{grant_valid: 1'b1, grant_slot: SLOT_W'(best_idx_ff),
                          request_queued: 1'b0, lock_busy: 1'b1, status: STATUS_OK};
            end else begin
               lock_held_in = 1'b0;
               rsp_in = '{grant_valid: 1'b0, grant_slot: '0, request_queued: 1'b0,
                          lock_busy: 1'b0, status: STATUS_OK};
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         scan_ff       <= '0;
         live_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         lock_held_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         scan_ff       <= scan_in;
         live_ff       <= live_in;
         best_valid_ff <= best_valid_in;
         lock_held_ff  <= lock_held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      live_idx_ff  <= live_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      rsp_ff       <= rsp_in;
   end

   // Pending store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `OFLA_ASSERT_IMPLY(a_exec_pop_idle, pop, state_ff == ST_IDLE, "queue popped outside idle")
   `OFLA_ASSERT_NEXT(a_exec_scan_beat, state_ff == ST_SCAN && scan_done, rsp_valid_ff && state_ff == ST_IDLE, "scan finished without a result beat")
   `OFLA_ASSERT_IMPLY(a_exec_grant_busy, rsp_valid_ff && rsp_ff.grant_valid, rsp_ff.lock_busy && rsp_ff.status == STATUS_OK, "grant beat shows a free lock")

endmodule

// File: rtl/oldest_first_lock_arbiter_core.sv
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter core
// Hardware lock that hands ownership to the oldest pending requester.
// ---------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; each beat yields
// exactly one result beat, shown for a single cycle under rsp_valid, which the
// receiver must take as it comes. Requests pass through a two-entry queue to
// the execution unit. A release of a held lock occupies the execution unit
// while the pending-time memory is scanned one slot per cycle through its
// single read port. After reset, busy stays high while the pending store is
// cleared one entry per cycle. Results come out in request order.
`timescale 1ns / 1ps

module oldest_first_lock_arbiter_core
   import ofla_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [SLOT_W-1:0]   req_requester_slot,
   input  logic [TIME_W-1:0]   req_request_time,
   output logic                rsp_valid,
   output logic                rsp_grant_valid,
   output logic [SLOT_W-1:0]   rsp_grant_slot,
   output logic                rsp_request_queued,
   output logic                rsp_lock_busy,
   output logic                rsp_status
);

   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;
   queue_status_type q_stat;
   front_ctl_type    front_ctl;
   logic             clearing;
   rsp_type          rsp;

   assign front_ctl.queue_full = q_stat.full;
   assign front_ctl.clearing   = clearing;

   // Request intake and classification.
   ofla_intake #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_intake (
      .start              (start),
      .req_mode           (req_mode),
      .req_requester_slot (req_requester_slot),
      .req_request_time   (req_request_time),
      .ctl                (front_ctl),
      .busy               (busy),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   // Queue between intake and execution.
   ofla_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   // Lock state, pending store and oldest-request scan.
   ofla_exec #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // Result beat fields.
   assign rsp_grant_valid    = rsp.grant_valid;
   assign rsp_grant_slot     = rsp.grant_slot;
   assign rsp_request_queued = rsp.request_queued;
   assign rsp_lock_busy      = rsp.lock_busy;
   assign rsp_status         = rsp.status;

endmodule

// File: bench/lock_handoff_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lock handoff checker
// Watches the request and result channels of the oldest-first lock arbiter.
// It keeps its own copy of the lock and of the pending table, works out the
// result of every accepted request, and compares each result beat field by
// field with the oldest outstanding expectation.
// ---------------------------------------------------------------------------

module lock_handoff_checker
   import ofla_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_mode,
   input  logic [SLOT_W-1:0] req_requester_slot,
   input  logic [TIME_W-1:0] req_request_time,
   input  logic              rsp_valid,
   input  logic              rsp_grant_valid,
   input  logic [SLOT_W-1:0] rsp_grant_slot,
   input  logic              rsp_request_queued,
   input  logic              rsp_lock_busy,
   input  logic              rsp_status,
   output int                fail_count,
   output int                results_due
);

   // Beyond this many mismatches the count goes on but nothing more is printed.
   localparam int PRINT_CAP = 40;

   // Shadow copy of the arbiter state.
   logic [TIME_W-1:0] waiting_stamp [SLOT_COUNT_DEF];
   logic              waiting_flag  [SLOT_COUNT_DEF];
   logic              lock_taken;

   // Results owed by the block, oldest first.
   rsp_type           expected_outcomes [$];

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP) begin
         $display("[%0t] lock handoff check: %s", $time, what);
      end
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [TIME_W-1:0] got,
                                input logic [TIME_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Applies one request to the shadow state and returns the result it owes.
   function automatic rsp_type predict_handoff(input op_type op,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [TIME_W-1:0] stamp);
      rsp_type outcome;
      int      oldest;
      outcome        = '0;
      outcome.status = STATUS_OK;
      if (op == OP_ACQUIRE) begin
         if (!lock_taken) begin
            // An idle lock goes straight to the requester.
            lock_taken          = 1'b1;
            outcome.grant_valid = 1'b1;
            outcome.grant_slot  = slot;
         end else if (int'(slot) < SLOT_COUNT_DEF) begin
            // A held lock records the request; a repeat overwrites the stamp.
            waiting_stamp[slot]    = stamp;
            waiting_flag[slot]     = 1'b1;
            outcome.request_queued = 1'b1;
         end
      end else if (!lock_taken) begin
         outcome.status = STATUS_IDLE_RELEASE;
      end else begin
         // Oldest stamp wins; the strict compare keeps the lowest slot on a tie.
         oldest = -1;
         for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
            if (waiting_flag[s] && (oldest < 0 || waiting_stamp[s] < waiting_stamp[oldest])) begin
               oldest = s;
            end
         end
         if (oldest >= 0) begin
            waiting_flag[oldest] = 1'b0;
            outcome.grant_valid  = 1'b1;
            outcome.grant_slot   = SLOT_W'(oldest);
         end else begin
            lock_taken = 1'b0;
         end
      end
      outcome.lock_busy = lock_taken;
      return outcome;
   endfunction

   // Check result beats, then predict for a newly accepted request beat.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lock_taken = 1'b0;
         foreach (waiting_flag[s]) begin
            waiting_flag[s] = 1'b0;
         end
         expected_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("grant_valid", TIME_W'(rsp_grant_valid),
                             TIME_W'(want.grant_valid));
               compare_field("grant_slot", TIME_W'(rsp_grant_slot),
                             TIME_W'(want.grant_slot));
               compare_field("request_queued", TIME_W'(rsp_request_queued),
                             TIME_W'(want.request_queued));
               compare_field("lock_busy", TIME_W'(rsp_lock_busy),
                             TIME_W'(want.lock_busy));
               compare_field("status", TIME_W'(rsp_status), TIME_W'(want.status));
            end
         end
         if (start && !busy) begin
            expected_outcomes.push_back(predict_handoff(op_type'(req_mode),
                                                        req_requester_slot,
                                                        req_request_time));
         end
      end
      results_due = expected_outcomes.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Oldest-first lock arbiter regression
// Drives directed and random acquire/release traffic with random gaps into
// the arbiter core; a checker beside the block predicts and compares every
// result beat, and this module gives the verdict.
// ---------------------------------------------------------------------------

module testbench;
   import ofla_pkg::*;

   localparam int              TOTAL_BEATS    = 470;
   localparam int              SETTLE_CYCLES  = 160;
   localparam int              WATCHDOG_LIMIT = 2000;
   localparam logic [TIME_W-1:0] STAMP_MAX    = 64'hFFFF_FFFF_FFFF_FFFE;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_mode;
   logic [SLOT_W-1:0] req_requester_slot;
   logic [TIME_W-1:0] req_request_time;
   logic              rsp_valid;
   logic              rsp_grant_valid;
   logic [SLOT_W-1:0] rsp_grant_slot;
   logic              rsp_request_queued;
   logic              rsp_lock_busy;
   logic              rsp_status;
   int                fail_count;
   int                results_due;
   int                beats_sent;
   int                burst_left;
   int                quiet_cycles;

   oldest_first_lock_arbiter_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_requester_slot (req_requester_slot),
      .req_request_time   (req_request_time),
      .rsp_valid          (rsp_valid),
      .rsp_grant_valid    (rsp_grant_valid),
      .rsp_grant_slot     (rsp_grant_slot),
      .rsp_request_queued (rsp_request_queued),
      .rsp_lock_busy      (rsp_lock_busy),
      .rsp_status         (rsp_status)
   );

   lock_handoff_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_requester_slot (req_requester_slot),
      .req_request_time   (req_request_time),
      .rsp_valid          (rsp_valid),
      .rsp_grant_valid    (rsp_grant_valid),
      .rsp_grant_slot     (rsp_grant_slot),
      .rsp_request_queued (rsp_request_queued),
      .rsp_lock_busy      (rsp_lock_busy),
      .rsp_status         (rsp_status),
      .fail_count         (fail_count),
      .results_due        (results_due)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("oldest_first_lock_arbiter_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Timestamps lean toward ties and the extremes; never above the legal top.
   function automatic logic [TIME_W-1:0] draw_stamp();
      logic [TIME_W-1:0] stamp;
      case ($urandom_range(0, 3))
         0: stamp = TIME_W'($urandom_range(0, 7));
         1: stamp = STAMP_MAX - TIME_W'($urandom_range(0, 7));
         default: stamp = {$urandom, $urandom};
      endcase
      if (stamp > STAMP_MAX) begin
         stamp = STAMP_MAX;
      end
      return stamp;
   endfunction

   // A small slot pool makes repeated requests from the same slot common.
   function automatic logic [SLOT_W-1:0] draw_slot();
      logic [SLOT_W-1:0] slot;
      case ($urandom_range(0, 3))
         0: slot = SLOT_W'($urandom_range(0, 3));
         1: slot = $urandom_range(0, 1) ? SLOT_W'(SLOT_COUNT_DEF - 1) : '0;
         default: slot = SLOT_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
      endcase
      return slot;
   endfunction

   // Sends one request beat after a random gap; entered and left at a falling edge.
   task automatic issue_beat(input op_type op, input logic [SLOT_W-1:0] slot,
                             input logic [TIME_W-1:0] stamp);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(4, 24);
         end
      end
      if (gap > 0) begin
         // Idle cycles carry junk on the request fields.
         start              <= 1'b0;
         req_mode           <= 1'($urandom_range(0, 1));
         req_requester_slot <= SLOT_W'($urandom);
         req_request_time   <= {$urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
      start              <= 1'b1;
      req_mode           <= op;
      req_requester_slot <= slot;
      req_request_time   <= stamp;
      do @(posedge clock); while (busy);
      @(negedge clock);
      beats_sent++;
   endtask

   initial begin
      int acquires;
      reset              = 1'b1;
      start              = 1'b0;
      req_mode           = OP_ACQUIRE;
      req_requester_slot = '0;
      req_request_time   = '0;
      beats_sent         = 0;
      burst_left         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle release, idle grant, ties, overwrites, own-slot request.
      issue_beat(OP_RELEASE, SLOT_W'(SLOT_COUNT_DEF - 1), STAMP_MAX);
      issue_beat(OP_ACQUIRE, '0, '0);
      issue_beat(OP_ACQUIRE, SLOT_W'(SLOT_COUNT_DEF - 1), STAMP_MAX);
      issue_beat(OP_ACQUIRE, 6'd5, 64'd100);
      issue_beat(OP_ACQUIRE, 6'd7, 64'd100);
      issue_beat(OP_ACQUIRE, 6'd0, 64'd100);
      issue_beat(OP_ACQUIRE, 6'd0, 64'd300);
      issue_beat(OP_RELEASE, 6'd9, 64'd1);
      issue_beat(OP_ACQUIRE, 6'd5, 64'd0);
      issue_beat(OP_RELEASE, '1, '0);
      issue_beat(OP_RELEASE, '0, STAMP_MAX);
      issue_beat(OP_RELEASE, 6'd7, 64'd100);
      issue_beat(OP_RELEASE, 6'd5, 64'd5);
      issue_beat(OP_RELEASE, 6'd0, 64'd0);
      issue_beat(OP_RELEASE, 6'd63, 64'd63);
      issue_beat(OP_ACQUIRE, 6'd42, 64'h5555_5555_5555_5555);
      issue_beat(OP_ACQUIRE, 6'd21, 64'hAAAA_AAAA_AAAA_AAAA);
      issue_beat(OP_RELEASE, 6'd42, 64'h0123_4567_89AB_CDEF);
      issue_beat(OP_RELEASE, 6'd21, 64'hFEDC_BA98_7654_3210);

      // Random: mostly whole lock episodes, now and then a run of noise.
      while (beats_sent < TOTAL_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               issue_beat(op_type'($urandom_range(0, 1)), draw_slot(), draw_stamp());
            end
         end else begin
            acquires = 1;
            issue_beat(OP_ACQUIRE, draw_slot(), draw_stamp());
            repeat ($urandom_range(0, 14)) begin
               if ($urandom_range(0, 99) < 65) begin
                  issue_beat(OP_ACQUIRE, draw_slot(), draw_stamp());
                  acquires++;
               end else begin
                  issue_beat(OP_RELEASE, draw_slot(), draw_stamp());
               end
            end
            // Drain the waiters, sometimes with one release too many.
            repeat (acquires + $urandom_range(0, 1)) begin
               issue_beat(OP_RELEASE, draw_slot(), draw_stamp());
            end
         end
      end
      start <= 1'b0;

      // Wait for every owed result, then watch a while for stray beats.
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("oldest_first_lock_arbiter_core regression: pass");
      end else begin
         $display("oldest_first_lock_arbiter_core regression: fail");
      end
      $finish;
   end

endmodule
